>>> design/point_set_fit_to_screen_defines.svh
// Assertion macros for the point set fit-to-screen block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef POINT_SET_FIT_TO_SCREEN_DEFINES_SVH
`define POINT_SET_FIT_TO_SCREEN_DEFINES_SVH

// same-cycle implication
`define PSF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psf assertion failed");

// next-cycle implication
`define PSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psf assertion failed");

`endif

>>> design/psf_pkg.sv
// Package for the point set fit-to-screen block: sizes, codes, state type.
// No dependencies.
package psf_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 32;
    localparam int DIM_W      = 13;
    localparam int EXT_W      = 32;
    localparam int PROD_W     = EXT_W + DIM_W;
    localparam int OFFS_W     = COORD_W + 2;
    localparam int FRAC_SH    = 16;
    localparam int NUM_W      = PROD_W + FRAC_SH + 1;
    localparam int REM_W      = EXT_W + 1;
    localparam int QUO_W      = NUM_W - REM_W;
    localparam int STEP_W     = $clog2(QUO_W + 1);
    localparam int WORD_W     = 2 * COORD_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] SCREEN_DIM_RESET = 13'd450;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SIZE,
        ST_PROD,
        ST_PICK,
        ST_READ,
        ST_OFFS,
        ST_MULT,
        ST_START,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

>>> design/point_set_fit_to_screen.sv
// Points load one per cycle into a 64-entry RAM while the bounding box is
// tracked. The point marked last starts the fit: the size, product and pick
// states choose the scale, then each stored point passes through RAM read,
// offset, multiply, a 29-step bit-serial divider per axis and output before
// it is offered, and the output holds while out_ready is low. No input is
// taken until the last result's transfer.
module point_set_fit_to_screen (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [psf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic                             last_point,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               screen_x,
    output logic signed [31:0]               screen_y,
    output logic                             last_of_run,
    output logic                             degenerate,
    output logic                             overflowed
);
    import psf_pkg::*;

    `include "point_set_fit_to_screen_defines.svh"

    state_t state_reg, state_next;

    logic [DIM_W-1:0]          width_reg, height_reg;
    logic signed [COORD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [CNT_W-1:0]          held_reg;
    logic                      drop_reg;
    logic [CNT_W-1:0]          idx_reg;

    logic [EXT_W-1:0]  xsize_reg, ysize_reg;
    logic [PROD_W-1:0] xcmp_reg, ycmp_reg;
    logic [DIM_W-1:0]  scale_reg;
    logic [EXT_W-1:0]  extent_reg;
    logic              degen_reg;

    logic [EXT_W-1:0]  mag_x_reg, mag_y_reg;
    logic              neg_x_reg, neg_y_reg;
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;

    logic signed [COORD_W-1:0] sx_reg, sy_reg;
    logic                      last_reg, degen_out_reg, drop_out_reg;

    logic in_xfer, out_xfer, store_en, div_start, busy_x, busy_y;
    logic [WORD_W-1:0] rd_word;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [OFFS_W-1:0] off_x, off_y;
    logic [NUM_W-1:0] num_x, num_y;
    logic [QUO_W-1:0] q_x, q_y, qx_eff, qy_eff;
    logic [COORD_W-1:0] ctr_x, ctr_y, fit_x, fit_y;

    assign in_ready  = state_reg == ST_LOAD;
    assign out_valid = state_reg == ST_EMIT;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    assign store_en  = in_xfer && (held_reg < CNT_W'(MAX_POINTS));
    assign div_start = state_reg == ST_START;

    psf_mem u_mem (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (held_reg[ADDR_W-1:0]),
        .wr_data ({point_x, point_y}),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_word)
    );

    assign rd_x = rd_word[WORD_W-1:COORD_W];
    assign rd_y = rd_word[COORD_W-1:0];

    // doubled offset from the box middle, exact
    assign off_x = {rd_x[COORD_W-1], rd_x, 1'b0}
                 - {{2{min_x_reg[COORD_W-1]}}, min_x_reg}
                 - {{2{max_x_reg[COORD_W-1]}}, max_x_reg};
    assign off_y = {rd_y[COORD_W-1], rd_y, 1'b0}
                 - {{2{min_y_reg[COORD_W-1]}}, min_y_reg}
                 - {{2{max_y_reg[COORD_W-1]}}, max_y_reg};

    // round to nearest: (2*num + z) / (2*z)
    assign num_x = {1'b0, prod_x_reg, {FRAC_SH{1'b0}}} + NUM_W'(extent_reg);
    assign num_y = {1'b0, prod_y_reg, {FRAC_SH{1'b0}}} + NUM_W'(extent_reg);

    psf_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_x),
        .divisor  ({extent_reg, 1'b0}),
        .busy     (busy_x),
        .quotient (q_x)
    );

    psf_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_y),
        .divisor  ({extent_reg, 1'b0}),
        .busy     (busy_y),
        .quotient (q_y)
    );

    // magnitude stays below 2^29, so the sum never needs saturation
    assign qx_eff = degen_reg ? '0 : q_x;
    assign qy_eff = degen_reg ? '0 : q_y;
    assign ctr_x  = {4'b0, width_reg, 15'b0};
    assign ctr_y  = {4'b0, height_reg, 15'b0};
    assign fit_x  = neg_x_reg ? ctr_x - COORD_W'(qx_eff) : ctr_x + COORD_W'(qx_eff);
    assign fit_y  = neg_y_reg ? ctr_y - COORD_W'(qy_eff) : ctr_y + COORD_W'(qy_eff);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && last_point)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:  state_next = ST_PROD;
            ST_PROD:  state_next = ST_PICK;
            ST_PICK:  state_next = ST_READ;
            ST_READ:  state_next = ST_OFFS;
            ST_OFFS:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (!busy_x && !busy_y)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    state_next = last_reg ? ST_LOAD : ST_READ;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            width_reg  <= SCREEN_DIM_RESET;
            height_reg <= SCREEN_DIM_RESET;
            min_x_reg  <= '0;
            max_x_reg  <= '0;
            min_y_reg  <= '0;
            max_y_reg  <= '0;
            held_reg   <= '0;
            drop_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (store_en)
            begin
                held_reg <= held_reg + 1'b1;
                if (held_reg == '0)
                begin
                    min_x_reg <= point_x;
                    max_x_reg <= point_x;
                    min_y_reg <= point_y;
                    max_y_reg <= point_y;
                end
                else
                begin
                    if (point_x < min_x_reg) min_x_reg <= point_x;
                    if (point_x > max_x_reg) max_x_reg <= point_x;
                    if (point_y < min_y_reg) min_y_reg <= point_y;
                    if (point_y > max_y_reg) max_y_reg <= point_y;
                end
            end
            else if (in_xfer)
            begin
                drop_reg <= 1'b1;
            end
            if (in_xfer && last_point)
            begin
                idx_reg <= '0;
            end
            if (out_xfer)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last_reg)
                begin
                    held_reg  <= '0;
                    drop_reg  <= 1'b0;
                    min_x_reg <= '0;
                    max_x_reg <= '0;
                    min_y_reg <= '0;
                    max_y_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SIZE)
        begin
            xsize_reg <= EXT_W'(max_x_reg - min_x_reg);
            ysize_reg <= EXT_W'(max_y_reg - min_y_reg);
        end
        if (state_reg == ST_PROD)
        begin
            xcmp_reg <= height_reg * xsize_reg;
            ycmp_reg <= width_reg * ysize_reg;
        end
        if (state_reg == ST_PICK)
        begin
            degen_reg <= (xsize_reg == '0) && (ysize_reg == '0);
            if (xsize_reg == '0)
            begin
                scale_reg  <= height_reg;
                extent_reg <= ysize_reg;
            end
            else if ((ysize_reg == '0) || (ycmp_reg < xcmp_reg))
            begin
                scale_reg  <= width_reg;
                extent_reg <= xsize_reg;
            end
            else
            begin
                scale_reg  <= height_reg;
                extent_reg <= ysize_reg;
            end
        end
        if (state_reg == ST_OFFS)
        begin
            neg_x_reg <= off_x[OFFS_W-1];
            neg_y_reg <= off_y[OFFS_W-1];
            mag_x_reg <= off_x[OFFS_W-1] ? EXT_W'(-off_x) : EXT_W'(off_x);
            mag_y_reg <= off_y[OFFS_W-1] ? EXT_W'(-off_y) : EXT_W'(off_y);
        end
        if (state_reg == ST_MULT)
        begin
            prod_x_reg <= mag_x_reg * scale_reg;
            prod_y_reg <= mag_y_reg * scale_reg;
        end
        if ((state_reg == ST_DIV) && (state_next == ST_EMIT))
        begin
            sx_reg        <= fit_x;
            sy_reg        <= fit_y;
            last_reg      <= idx_reg == held_reg - 1'b1;
            degen_out_reg <= degen_reg;
            drop_out_reg  <= drop_reg;
        end
    end

    assign screen_x    = sx_reg;
    assign screen_y    = sy_reg;
    assign last_of_run = last_reg;
    assign degenerate  = degen_out_reg;
    assign overflowed  = drop_out_reg;

    `PSF_ASSERT_NOW(a_no_load_while_emit, out_valid, !in_ready)
    `PSF_ASSERT_NOW(a_held_in_range, 1'b1, held_reg <= CNT_W'(MAX_POINTS))
    `PSF_ASSERT_NEXT(a_run_end_clears, out_xfer && last_of_run, held_reg == '0 && !drop_reg)
    `PSF_ASSERT_NEXT(a_full_drops, in_xfer && held_reg == CNT_W'(MAX_POINTS), drop_reg)

endmodule

>>> design/psf_mem.sv
// Point store: one synchronous RAM of {x, y} words, one write and one read port.
// Read data registered. Depends on psf_pkg.
module psf_mem (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [psf_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [psf_pkg::WORD_W-1:0]   wr_data,
    input  logic [psf_pkg::ADDR_W-1:0]   rd_addr,
    output logic [psf_pkg::WORD_W-1:0]   rd_data
);
    import psf_pkg::*;

    logic [WORD_W-1:0] mem [MAX_POINTS];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/psf_div.sv
// Restoring divider, one quotient bit per cycle.
// Caller guarantees the quotient fits in QUO_W bits. Depends on psf_pkg.
module psf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [psf_pkg::NUM_W-1:0]   dividend,
    input  logic [psf_pkg::REM_W-1:0]   divisor,
    output logic                        busy,
    output logic [psf_pkg::QUO_W-1:0]   quotient
);
    import psf_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [REM_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, low_reg[QUO_W-1]};
        fits      = trial >= {1'b0, divisor};
        step_next = step_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        if (start)
        begin
            step_next = STEP_W'(QUO_W);
            rem_next  = dividend[NUM_W-1:QUO_W];
            low_next  = dividend[QUO_W-1:0];
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - 1'b1;
            rem_next  = fits ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
            low_next  = {low_reg[QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign busy     = step_reg != '0;
    assign quotient = low_reg;

endmodule

>>> verif/point_set_fit_to_screen_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for point_set_fit_to_screen: loads point sets, predicts
// the fitted screen points in order and checks every output transfer field by field.
// Depends on psf_pkg and the point_set_fit_to_screen RTL.
module point_set_fit_to_screen_tb;
    import psf_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } src_pt_t;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               lst;
        logic               degen;
        logic               ovf;
    } screen_pt_t;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [31:0]    point_x = '0;
    logic signed [31:0]    point_y = '0;
    logic                  last_point = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [31:0]    screen_x;
    logic signed [31:0]    screen_y;
    logic                  last_of_run;
    logic                  degenerate;
    logic                  overflowed;

    // predictor state
    logic [DIM_W-1:0] fit_w = SCREEN_DIM_RESET;
    logic [DIM_W-1:0] fit_h = SCREEN_DIM_RESET;
    longint           pts_x [MAX_POINTS];
    longint           pts_y [MAX_POINTS];
    longint           lo_x, hi_x, lo_y, hi_y;
    int               held;
    logic             dropped;

    src_pt_t    points_to_send [$];
    screen_pt_t fitted_pts [$];
    int         items_queued;
    int         items_taken;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         errors;
    logic       holding;
    src_pt_t    nxt;
    screen_pt_t want;

    point_set_fit_to_screen uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .last_of_run (last_of_run),
        .degenerate  (degenerate),
        .overflowed  (overflowed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_v);
        if (got !== exp_v)
            report_mismatch($sformatf("%s got %h want %h", name, got, exp_v));
    endtask

    // one axis: screen centre plus round(d*S*32768/Z), ties away from zero, saturated
    function automatic logic [31:0] map_to_screen(input longint p, input longint lo,
                                                  input longint hi, input longint unsigned s,
                                                  input longint unsigned z,
                                                  input longint unsigned axis_s);
        longint          res;
        longint          d;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned q;
        res = axis_s * 32768;
        if (z != 0)
        begin
            d   = 2 * p - lo - hi;
            mag = (d < 0) ? -d : d;
            num = mag * s * 32768;
            q   = (2 * num + z) / (2 * z);
            res = (d < 0) ? res - longint'(q) : res + longint'(q);
        end
        if (res > 64'sh7FFF_FFFF)
            res = 64'sh7FFF_FFFF;
        if (res < -64'sh8000_0000)
            res = -64'sh8000_0000;
        return res[31:0];
    endfunction

    function automatic void fit_track_point(input longint px, input longint py, input logic lp);
        longint unsigned xsz;
        longint unsigned ysz;
        longint unsigned s;
        longint unsigned z;
        logic            degen;
        screen_pt_t      r;
        if (held < MAX_POINTS)
        begin
            if (held == 0)
            begin
                lo_x = px; hi_x = px; lo_y = py; hi_y = py;
            end
            else
            begin
                if (px < lo_x) lo_x = px;
                if (px > hi_x) hi_x = px;
                if (py < lo_y) lo_y = py;
                if (py > hi_y) hi_y = py;
            end
            pts_x[held] = px;
            pts_y[held] = py;
            held++;
        end
        else
            dropped = 1'b1;
        if (!lp)
            return;
        xsz   = hi_x - lo_x;
        ysz   = hi_y - lo_y;
        degen = (xsz == 0 && ysz == 0);
        if (degen)
        begin
            s = 0; z = 0;
        end
        else if (xsz == 0)
        begin
            s = fit_h; z = ysz;
        end
        else if (ysz == 0)
        begin
            s = fit_w; z = xsz;
        end
        else if (fit_w * ysz < fit_h * xsz)
        begin
            s = fit_w; z = xsz;
        end
        else
        begin
            s = fit_h; z = ysz;
        end
        for (int k = 0; k < held; k++)
        begin
            r.sx    = map_to_screen(pts_x[k], lo_x, hi_x, s, z, fit_w);
            r.sy    = map_to_screen(pts_y[k], lo_y, hi_y, s, z, fit_h);
            r.lst   = (k == held - 1);
            r.degen = degen;
            r.ovf   = dropped;
            fitted_pts.push_back(r);
        end
        held    = 0;
        dropped = 1'b0;
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            point_x    <= '0;
            point_y    <= '0;
            last_point <= 1'b0;
        end
        else
        begin
            holding = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                fit_track_point(point_x, point_y, last_point);
                items_taken++;
            end
            if (!holding)
            begin
                if (points_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = points_to_send.pop_front();
                    in_valid   <= 1'b1;
                    point_x    <= nxt.x;
                    point_y    <= nxt.y;
                    last_point <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (fitted_pts.size() == 0)
                    report_mismatch("screen point transfer with none pending");
                else
                begin
                    want = fitted_pts.pop_front();
                    check_field("screen_x", screen_x, want.sx);
                    check_field("screen_y", screen_y, want.sy);
                    check_field("last_of_run", last_of_run, want.lst);
                    check_field("degenerate", degenerate, want.degen);
                    check_field("overflowed", overflowed, want.ovf);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_point(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic lp);
        src_pt_t p;
        p.x = x; p.y = y; p.last = lp;
        points_to_send.push_back(p);
        items_queued++;
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_random_set(input int n);
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] x;
        logic signed [31:0] y;
        int                 shape;
        bx    = $urandom();
        by    = $urandom();
        shape = $urandom_range(9);
        for (int k = 0; k < n; k++)
        begin
            x = bx + $urandom_range(4095) - 2048;
            y = by + $urandom_range(4095) - 2048;
            case (shape)
                0, 1, 2:
                begin
                    x = $urandom(); y = $urandom();
                end
                6: x = bx;
                7: y = by;
                8:
                begin
                    x = bx; y = by;
                end
                9:
                begin
                    x = pick_extreme(); y = pick_extreme();
                end
                default: ;
            endcase
            queue_point(x, y, k == n - 1);
        end
    endtask

    task automatic write_screen_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            fit_w = val;
        else
            fit_h = val;
    endtask

    task automatic drain_phase();
        while (items_taken != items_queued || fitted_pts.size() != 0)
            @(posedge clk);
        // short idle gap before the next phase
        repeat (40) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct  = (mode == 1) ? 82 : (mode == 3) ? 38 : 0;
        recv_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 38 : 0;
    endtask

    initial
    begin
        logic [DIM_W-1:0] w_set [6];
        logic [DIM_W-1:0] h_set [6];
        int               added;
        int               n;
        w_set = '{13'd450, 13'd1, 13'd4096, 13'd4096, 13'd1, 13'd0};
        h_set = '{13'd450, 13'd4096, 13'd1, 13'd4096, 13'd1, 13'd0};
        w_set[5] = DIM_W'($urandom_range(1, 4096));
        h_set[5] = DIM_W'($urandom_range(1, 4096));
        errors       = 0;
        items_queued = 0;
        items_taken  = 0;
        held         = 0;
        dropped      = 1'b0;
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
        set_idling(0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets under reset screen size
        queue_point(32'sd0, 32'sd0, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, COORD_MAX, 1'b1);
        queue_point(COORD_MAX, COORD_MIN, 1'b0);
        queue_point(COORD_MIN, COORD_MAX, 1'b0);
        queue_point(32'sd0, 32'sd0, 1'b1);
        queue_point(32'sh0001_0000, 32'sd5, 1'b0);
        queue_point(32'sh0001_0000, -32'sh0003_0000, 1'b0);
        queue_point(32'sh0001_0000, 32'sh0000_7000, 1'b1);
        queue_point(-32'sd7, 32'sh123, 1'b0);
        queue_point(32'sh0004_5678, 32'sh123, 1'b1);
        queue_point(-32'sh0010_0000, 32'sd0, 1'b0);
        queue_point(32'sh0010_0000, 32'sh10, 1'b0);
        queue_point(32'sd3, 32'sd8, 1'b1);
        queue_point(COORD_MAX, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, COORD_MIN, 1'b1);
        drain_phase();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                write_screen_reg(REG_SCREEN_WIDTH, w_set[ph]);
                write_screen_reg(REG_SCREEN_HEIGHT, h_set[ph]);
            end
            set_idling(ph % 4);
            // capacity overflow: 64 stored, the last two dropped incl. the last point
            if (ph == 3)
                queue_random_set(MAX_POINTS + 2);
            else
            begin
                added = 0;
                while (added < 3)
                begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(9, 20)
                                                 : $urandom_range(1, 6);
                    queue_random_set(n);
                    added += n;
                end
            end
            drain_phase();
        end

        repeat (60) @(posedge clk);
        if (errors == 0 && fitted_pts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
